// ===== design/rsmp_pkg.sv =====
package rsmp_pkg;

   localparam int unsigned ResidualWidth = 11;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned HoldWidth     = 7;
   localparam int unsigned CountWidth    = 3;
   localparam int unsigned CodeWidth     = 10;
   localparam int unsigned AccWidth      = HoldWidth + CodeWidth;
   localparam int unsigned MaxBytes      = 3;
   localparam int unsigned NumWidth      = 2;
   localparam int unsigned ReqDataWidth  = 16;

   localparam logic signed [ResidualWidth-1:0] SatHigh = 11'sd255;
   localparam logic signed [ResidualWidth-1:0] SatLow  = -11'sd255;

   // bytes of one item, first byte in entry 0
   typedef struct packed {
      logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
      logic [NumWidth-1:0]                count;
      logic                               stream_end;
   } group_type;

endpackage

// ===== design/rsmp_pack.sv =====
module rsmp_pack
   import rsmp_pkg::*;
(
   input  logic signed [ResidualWidth-1:0] residual,
   input  logic                            final_item,
   input  logic [HoldWidth-1:0]            pend_bits,
   input  logic [CountWidth-1:0]           pend_count,
   output logic [HoldWidth-1:0]            next_bits,
   output logic [CountWidth-1:0]           next_count,
   output group_type                       group
);

   logic signed [ResidualWidth-1:0] sat;
   logic signed [ResidualWidth-1:0] abs_val;
   logic [CodeWidth-1:0]            code;
   logic [3:0]                      len;
   logic [4:0]                      total;
   logic [AccWidth-1:0]             acc;
   logic [MaxBytes*ByteWidth-1:0]   left;
   logic [HoldWidth-1:0]            rem_mask;
   logic [NumWidth-1:0]             full_count;
   logic [CountWidth-1:0]           rem;

   always_comb begin
      if (residual > SatHigh) begin
         sat = SatHigh;
      end else if (residual < SatLow) begin
         sat = SatLow;
      end else begin
         sat = residual;
      end
      abs_val = sat[ResidualWidth-1] ? -sat : sat;

      if (sat == '0) begin
         code = '0;
         len  = 4'd1;
      end else begin
         code = {1'b1, sat[ResidualWidth-1], abs_val[ByteWidth-1:0]};
         len  = 4'd10;
      end

      total = 5'(pend_count) + 5'(len);
      acc   = (AccWidth'(pend_bits) << len) | AccWidth'(code);
      // left-justify so every byte, including the padded tail, sits at a fixed place
      left  = (MaxBytes*ByteWidth)'(acc) << (5'd24 - total);

      full_count = total[4:3];
      rem        = total[2:0];
      rem_mask   = HoldWidth'((8'd1 << rem) - 8'd1);

      // earliest byte sits in the top bits of left and goes to entry 0
      group.bytes      = {left[7:0], left[15:8], left[23:16]};
      group.stream_end = final_item;
      if (final_item && rem != '0) begin
         group.count = full_count + 2'd1;
      end else begin
         group.count = full_count;
      end

      if (final_item) begin
         next_bits  = '0;
         next_count = '0;
      end else begin
         next_bits  = acc[HoldWidth-1:0] & rem_mask;
         next_count = rem;
      end
   end

endmodule

// ===== design/rsmp_emit.sv =====
module rsmp_emit
   import rsmp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   output logic                 load_ready,
   input  group_type            group,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ByteWidth-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   logic [MaxBytes-1:0][ByteWidth-1:0] bytes_ff;
   logic [NumWidth-1:0]                left_ff, left_in;
   logic [NumWidth-1:0]                idx_ff, idx_in;
   logic                               end_ff;
   logic                               take;
   logic                               load;

   assign rsp_tvalid = left_ff != '0;
   assign take       = rsp_tvalid && rsp_tready;
   assign load_ready = left_ff == '0 || (left_ff == 2'd1 && rsp_tready);
   assign load       = load_valid && load_ready;

   assign rsp_tdata = bytes_ff[idx_ff];
   assign rsp_tuser = left_ff == 2'd1;
   assign rsp_tlast = left_ff == 2'd1 && end_ff;

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (load) begin
         left_in = group.count;
         idx_in  = '0;
      end else if (take) begin
         left_in = left_ff - 2'd1;
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= group.bytes;
         end_ff   <= group.stream_end;
      end
   end

endmodule

// ===== design/residual_sign_magnitude_packer_top.sv =====
// Channel   Direction  tdata                       tlast        tuser
// req_      in         [10:0] residual (signed)    final_item   -
// rsp_      out        [7:0]  out_byte             stream_end   run_last
//
// An item is held in the input register, then its bytes (zero to three)
// leave the result buffer one beat per cycle while rsp_tready is high.
// The result buffer's single output port sets that rate.
// Reset (synchronous, active high) clears the held bits and both valid flags.
// A stalled rsp_ holds its beat; req_ keeps accepting while the input register
// can drain, and the held bits advance only when an item moves into the buffer.
module residual_sign_magnitude_packer_top
   import rsmp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // [10:0] residual
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [ByteWidth-1:0]    rsp_tdata,  // [7:0] out_byte
   output logic                    rsp_tlast,
   output logic                    rsp_tuser   // [0] run_last
);

   logic                            stg_valid_ff;
   logic signed [ResidualWidth-1:0] stg_residual_ff;
   logic                            stg_final_ff;
   logic [HoldWidth-1:0]            pend_bits_ff, pend_bits_in;
   logic [CountWidth-1:0]           pend_count_ff, pend_count_in;
   group_type                       group;
   logic                            emit_ready;
   logic                            advance;
   logic                            req_take;

   assign advance    = stg_valid_ff && emit_ready;
   assign req_tready = !stg_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   rsmp_pack u_pack (
      .residual   (stg_residual_ff),
      .final_item (stg_final_ff),
      .pend_bits  (pend_bits_ff),
      .pend_count (pend_count_ff),
      .next_bits  (pend_bits_in),
      .next_count (pend_count_in),
      .group      (group)
   );

   rsmp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (stg_valid_ff),
      .load_ready (emit_ready),
      .group      (group),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         if (req_tready) begin
            stg_valid_ff <= req_tvalid;
         end
         if (advance) begin
            pend_bits_ff  <= pend_bits_in;
            pend_count_ff <= pend_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_residual_ff <= req_tdata[ResidualWidth-1:0];
         stg_final_ff    <= req_tlast;
      end
   end

endmodule

// ===== test/residual_sign_magnitude_packer_top_test.sv =====
module residual_sign_magnitude_packer_top_test;
   import rsmp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ByteWidth-1:0] code_byte;
      logic                 run_last;
      logic                 stream_end;
   } coded_byte_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;   // [10:0] residual
   logic                    req_tlast;   // final_item
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [ByteWidth-1:0]    rsp_tdata;   // [7:0] out_byte
   logic                    rsp_tlast;   // stream_end
   logic                    rsp_tuser;   // [0] run_last

   // predictor state: held code bits, right-aligned, and how many are valid
   logic [HoldWidth-1:0]  held_bits;
   logic [CountWidth-1:0] held_count;

   coded_byte_type expected_bytes[$];

   bit idle_on;
   int rsp_hold_request;
   int fail_count;
   int residuals_sent;
   int finals_sent;
   int bytes_checked;

   residual_sign_magnitude_packer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Saturate, code and pack one residual; queue the bytes it completes.
   function automatic void pack_residual(input logic [ResidualWidth-1:0] raw,
                                         input logic fin);
      int                               value;
      int                               code_len;
      int                               total;
      logic [CodeWidth-1:0]             code;
      logic [AccWidth-1:0]              acc;
      coded_byte_type                   one;
      coded_byte_type                   fresh[$];
      value = int'($signed(raw));
      if (value > int'(SatHigh)) value = int'(SatHigh);
      if (value < int'(SatLow)) value = int'(SatLow);
      if (value == 0) begin
         code = '0;
         code_len = 1;
      end else begin
         code = {1'b1, value < 0, 8'(value < 0 ? -value : value)};
         code_len = CodeWidth;
      end
      total = int'(held_count);
      acc = AccWidth'(held_bits & HoldWidth'((1 << total) - 1));
      acc = (acc << code_len) | AccWidth'(code);
      total += code_len;
      while (total >= ByteWidth) begin
         one.code_byte = 8'(acc >> (total - ByteWidth));
         one.run_last = 1'b0;
         one.stream_end = 1'b0;
         fresh.push_back(one);
         total -= ByteWidth;
      end
      acc &= AccWidth'((1 << total) - 1);
      if (fin) begin
         // pad the partial byte with zeros; nothing is added on a byte boundary
         if (total > 0) begin
            one.code_byte = 8'(acc << (ByteWidth - total));
            one.run_last = 1'b0;
            one.stream_end = 1'b0;
            fresh.push_back(one);
         end
         held_bits = '0;
         held_count = '0;
      end else begin
         held_bits = HoldWidth'(acc);
         held_count = CountWidth'(total);
      end
      if (fresh.size() > 0) begin
         fresh[fresh.size()-1].run_last = 1'b1;
         fresh[fresh.size()-1].stream_end = fin;
      end
      foreach (fresh[i]) expected_bytes.push_back(fresh[i]);
   endfunction

   // Offer one residual from a falling edge and hold it until accepted.
   task automatic send_residual(input logic [ResidualWidth-1:0] raw, input logic fin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ReqDataWidth'(raw);
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      pack_residual(raw, fin);
      residuals_sent++;
      if (fin) finals_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [ResidualWidth-1:0] random_residual();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return '0;
      if (pick < 7) return ResidualWidth'(int'($urandom_range(0, 16)) - 8);
      if (pick < 9) return ResidualWidth'(int'($urandom_range(0, 510)) - 255);
      return ResidualWidth'($urandom_range(0, 2047));
   endfunction

   task automatic test_saturation_extremes();
      send_residual(11'sd0, 1'b1);
      send_residual(11'sd255, 1'b0);
      send_residual(-11'sd255, 1'b0);
      send_residual(11'sd256, 1'b0);
      send_residual(11'sd1023, 1'b0);
      send_residual(-11'sd256, 1'b0);
      send_residual(-11'sd1024, 1'b0);
      send_residual(11'sd127, 1'b0);
      send_residual(-11'sd128, 1'b0);
      send_residual(11'sd1, 1'b0);
      send_residual(-11'sd1, 1'b0);
      send_residual(11'sd0, 1'b1);
      wait_for_drain();
   endtask

   // seven zeros give no byte; a coded final item then yields three bytes
   task automatic test_three_byte_flush();
      repeat (7) send_residual(11'sd0, 1'b0);
      send_residual(-11'sd200, 1'b1);
      wait_for_drain();
   endtask

   // forty code bits end on a byte boundary, so no padding byte
   task automatic test_aligned_flush();
      send_residual(11'sd5, 1'b0);
      send_residual(-11'sd5, 1'b0);
      send_residual(11'sd100, 1'b0);
      send_residual(-11'sd100, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) idle_on = (i % 120 == 0);
         send_residual(random_residual(), $urandom_range(0, 11) == 0);
      end
      wait_for_drain();
   endtask

   // hold off the receiver while the sender keeps offering items
   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_request = 80;
      for (int i = 0; i < 40; i++)
         send_residual(ResidualWidth'(int'($urandom_range(1, 255)) * (i % 2 ? -1 : 1)),
                       i == 39);
      wait_for_drain();
   endtask

   task automatic test_steady_stream(input int count);
      idle_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_residual(random_residual(), i == count - 1 || $urandom_range(0, 11) == 0);
      wait_for_drain();
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      coded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte beat 0x%02h arrived with no expectation", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_tdata !== want.code_byte) begin
               $error("out_byte: expected 0x%02h, got 0x%02h", want.code_byte, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== want.stream_end) begin
               $error("stream_end: expected %0b, got %0b", want.stream_end, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      held_bits = '0;
      held_count = '0;
      idle_on = 1'b0;
      rsp_hold_request = 0;
      fail_count = 0;
      residuals_sent = 0;
      finals_sent = 0;
      bytes_checked = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_saturation_extremes();
      test_three_byte_flush();
      test_aligned_flush();
      test_random_mix(260);
      test_backpressure();
      test_steady_stream(120);

      if (expected_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", expected_bytes.size());
         fail_count++;
      end
      $display("Sent %0d residuals (%0d flushing) and checked %0d packed bytes,",
               residuals_sent, finals_sent, bytes_checked);
      $display("with saturation, silent items, padded and aligned flushes, long stall.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
